/* rtl/stb_pkg.sv */
package stb_pkg;

    localparam int NumTones   = 7;
    localparam int CfgW       = 14;
    localparam int FreqW      = 16;
    localparam int AmpW       = 16;
    localparam int SumW       = 32;
    localparam int FcW        = 23;
    localparam int CalcW      = 25;
    localparam int MinOctave  = 3;
    localparam int MaxOctave  = 9;
    localparam int FreqScale  = 100;
    localparam int AddrW      = 5;
    localparam int RegIdxW    = 3;
    localparam int ApbDataW   = 32;

    typedef logic [CfgW-1:0]  cfg_val_t;
    typedef logic [CalcW-1:0] calc_t;
    typedef logic [SumW-1:0]  sum_t;
    typedef logic [AmpW-1:0]  amp_t;

    typedef enum logic [RegIdxW-1:0] {
        REG_BASE_C    = 3'd0,
        REG_BASE_D    = 3'd1,
        REG_BASE_E    = 3'd2,
        REG_BASE_F    = 3'd3,
        REG_BASE_G    = 3'd4,
        REG_BASE_A    = 3'd5,
        REG_BASE_B    = 3'd6,
        REG_TOLERANCE = 3'd7
    } reg_idx_t;

    localparam cfg_val_t BaseReset [NumTones] = '{
        14'd1635, 14'd1835, 14'd2060, 14'd2283, 14'd2450, 14'd2750, 14'd3187
    };
    localparam cfg_val_t TolReset = 14'd100;

    function automatic calc_t scale_oct(cfg_val_t value, int octave);
        calc_t wide;
        wide = calc_t'(value);
        return wide << octave;
    endfunction

    function automatic sum_t sat_add(sum_t acc, amp_t amp);
        logic [SumW:0] total;
        total = {1'b0, acc} + {{(SumW + 1 - AmpW){1'b0}}, amp};
        return total[SumW] ? {SumW{1'b1}} : total[SumW-1:0];
    endfunction

endpackage

/* rtl/spectrum_tone_binner.sv */
// Output: once the last bin of a frame has passed stages s1, s2 and s3, the sums are registered and m_tvalid rises.
// Throughput: one bin per cycle unless a last bin waits for the output; octave and tone windows
// are all compared in parallel in one stage; the saturating accumulators take one bin per cycle.
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the seven
// accumulators and loads the default tone bases and tolerance.
module spectrum_tone_binner
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // frequency_hz, amplitude
    input  logic                             s_tlast,   // last_bin
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [stb_pkg::NumTones*32-1:0]  m_tdata,   // sum_c, sum_d, sum_e, sum_f, sum_g, sum_a, sum_b
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [stb_pkg::AddrW-1:0]        paddr,
    input  logic [stb_pkg::ApbDataW-1:0]     pwdata,
    output logic [stb_pkg::ApbDataW-1:0]     prdata,
    output logic                             pready
);
    import stb_pkg::*;

    cfg_val_t               base_reg [NumTones];
    cfg_val_t               tol_reg;
    reg_idx_t               cfg_idx;
    cfg_val_t               rd_val;
    logic                   cfg_write;

    logic                   s1_valid_reg;
    logic [FreqW-1:0]       s1_freq_reg;
    amp_t                   s1_amp_reg;
    logic                   s1_last_reg;
    logic                   s2_valid_reg;
    logic [FcW-1:0]         s2_fc_reg;
    amp_t                   s2_amp_reg;
    logic                   s2_last_reg;
    logic                   s3_valid_reg;
    logic [NumTones-1:0]    s3_mask_reg;
    amp_t                   s3_amp_reg;
    logic                   s3_last_reg;

    sum_t                   acc_reg [NumTones];
    sum_t                   sum_next [NumTones];
    logic                   out_valid_reg;
    sum_t                   out_sum_reg [NumTones];

    logic                   out_free;
    logic                   s1_ready;
    logic                   s2_ready;
    logic                   s3_ready;
    logic [MaxOctave:1]     oct_sel;
    logic [NumTones-1:0]    mask_next;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[AddrW-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign rd_val    = (cfg_idx == REG_TOLERANCE) ? tol_reg : base_reg[cfg_idx];
    assign prdata    = {{(ApbDataW - CfgW){1'b0}}, rd_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NumTones; t++)
            begin
                base_reg[t] <= BaseReset[t];
            end
            tol_reg <= TolReset;
        end
        else if (cfg_write)
        begin
            if (cfg_idx == REG_TOLERANCE)
            begin
                tol_reg <= pwdata[CfgW-1:0];
            end
            else
            begin
                base_reg[cfg_idx] <= pwdata[CfgW-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s3_ready = !s3_valid_reg || !s3_last_reg || out_free;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    // The first octave whose coarse window holds the bin selects the tone windows;
    // octaves one and two are found but contribute nothing.
    always_comb
    begin
        calc_t fc;
        calc_t tol_w;
        calc_t centre;
        calc_t half;
        logic  found;
        logic  hit;
        fc    = calc_t'(s2_fc_reg);
        tol_w = calc_t'(tol_reg);
        found = 1'b0;
        oct_sel = '0;
        for (int j = 1; j <= MaxOctave; j++)
        begin
            hit = (fc + tol_w > scale_oct(base_reg[REG_BASE_C], j))
                && (fc < scale_oct(base_reg[REG_BASE_B], j) + tol_w);
            oct_sel[j] = hit && !found && (j >= MinOctave);
            found = found | hit;
        end
        mask_next = '0;
        for (int t = 0; t < NumTones; t++)
        begin
            for (int j = MinOctave; j <= MaxOctave; j++)
            begin
                centre = scale_oct(base_reg[t], j);
                half   = scale_oct(tol_reg, j);
                if (oct_sel[j] && (fc + half > centre) && (fc < centre + half))
                begin
                    mask_next[t] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int t = 0; t < NumTones; t++)
        begin
            sum_next[t] = s3_mask_reg[t] ? sat_add(acc_reg[t], s3_amp_reg) : acc_reg[t];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < NumTones; t++)
            begin
                acc_reg[t] <= '0;
            end
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s3_valid_reg && s3_ready)
            begin
                for (int t = 0; t < NumTones; t++)
                begin
                    acc_reg[t] <= s3_last_reg ? '0 : sum_next[t];
                end
            end
            if (s3_valid_reg && s3_last_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_freq_reg <= s_tdata[FreqW-1:0];
            s1_amp_reg  <= s_tdata[FreqW+AmpW-1:FreqW];
            s1_last_reg <= s_tlast;
        end
        if (s2_ready)
        begin
            s2_fc_reg   <= FcW'(s1_freq_reg) * FcW'(FreqScale);
            s2_amp_reg  <= s1_amp_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready)
        begin
            s3_mask_reg <= mask_next;
            s3_amp_reg  <= s2_amp_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (s3_valid_reg && s3_last_reg && out_free)
        begin
            for (int t = 0; t < NumTones; t++)
            begin
                out_sum_reg[t] <= sum_next[t];
            end
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        for (int t = 0; t < NumTones; t++)
        begin
            m_tdata[t*SumW +: SumW] = out_sum_reg[t];
        end
    end

`ifndef NO_ASSERTIONS
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s3_valid_reg && s3_last_reg))
        else $error("result raised without a last bin in the final stage");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_last_reg && out_free) |=> m_tvalid)
        else $error("last bin consumed but no result presented");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("input stalled while the pipeline has a free stage");
`endif

endmodule
